[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[hdl/mrot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrot_pkg
// Shared constants and command type for the matrix rotate core
// ----------------------------------------------------------------------------
package mrot_pkg;

  localparam int MAX_SIDE_DEFAULT = 16;

  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam int OPCODE_W = 2;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ROTATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam int INDEX_W = 4;
  localparam int DATA_W  = 32;

  // controller to datapath commands
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic       wr_from_hold;
    logic [1:0] hold_sel;
    logic       cap_en;
    logic [1:0] cap_idx;
    logic       out_load;
    logic       out_zero;
  } dp_cmd_t;

endpackage

[hdl/mrot_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrot_dp
// Element store, rotation hold registers and result register
// ----------------------------------------------------------------------------
module mrot_dp #(
  parameter int MAX_SIDE = mrot_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  mrot_pkg::dp_cmd_t                   cmd,
  input  logic [$clog2(MAX_SIDE)-1:0]         rd_row,
  input  logic [$clog2(MAX_SIDE)-1:0]         rd_col,
  input  logic [$clog2(MAX_SIDE)-1:0]         wr_row,
  input  logic [$clog2(MAX_SIDE)-1:0]         wr_col,
  input  logic signed [mrot_pkg::DATA_W-1:0]  wr_value,
  output logic signed [mrot_pkg::DATA_W-1:0]  read_value
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [mrot_pkg::DATA_W-1:0] mem [DEPTH];
  logic [mrot_pkg::DATA_W-1:0] rdata;
  logic [mrot_pkg::DATA_W-1:0] hold [4];
  logic [mrot_pkg::DATA_W-1:0] wdata;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ADDR_W-1:0]           wr_addr;

  assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_col);
  assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(wr_col);
  assign wdata   = cmd.wr_from_hold ? hold[cmd.hold_sel] : wr_value;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // corner values of the current rotation step
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      hold[cmd.cap_idx] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value <= cmd.out_zero ? '0 : rdata;
    end
  end

endmodule

[hdl/mrot_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrot_ctrl
// Handshake, size register and rotation sequencer
// ----------------------------------------------------------------------------
module mrot_ctrl #(
  parameter int MAX_SIDE = mrot_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mrot_pkg::OPCODE_W-1:0]       opcode,
  input  logic [mrot_pkg::INDEX_W-1:0]        row,
  input  logic [mrot_pkg::INDEX_W-1:0]        col,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrot_pkg::SIZE_W-1:0]         cfg_data,
  output mrot_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(MAX_SIDE)-1:0]         rd_row,
  output logic [$clog2(MAX_SIDE)-1:0]         rd_col,
  output logic [$clog2(MAX_SIDE)-1:0]         wr_row,
  output logic [$clog2(MAX_SIDE)-1:0]         wr_col
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int N_W    = $clog2(MAX_SIDE + 1);

  typedef enum logic {
    ST_IDLE,
    ST_ROT
  } state_t;

  state_t                      state;
  logic [2:0]                  phase;
  logic [SIDE_W-1:0]           lo;
  logic [SIDE_W-1:0]           hi;
  logic [SIDE_W-1:0]           k;
  logic                        rd_pend;
  logic                        rd_inside;
  logic [mrot_pkg::SIZE_W-1:0] size_reg;

  logic [N_W-1:0]    n_eff;
  logic [SIDE_W-1:0] n_minus1;
  logic              in_range;
  logic              accept;
  logic              more_k;
  logic              more_layer;
  logic [SIDE_W-1:0] rot_row;
  logic [SIDE_W-1:0] rot_col;

  assign n_eff    = (32'(size_reg) > MAX_SIDE) ? N_W'(MAX_SIDE) : N_W'(size_reg);
  assign n_minus1 = SIDE_W'(32'(n_eff) - 32'd1);
  assign in_range = (32'(row) < 32'(n_eff)) && (32'(col) < 32'(n_eff));

  assign in_stall  = (state == ST_ROT) || rd_pend || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign more_k     = (32'(k) + 32'd1) < (32'(hi) - 32'(lo));
  assign more_layer = (32'(lo) + 32'd2) < 32'(hi);

  // corner of the step: top, left, bottom, right
  always_comb begin
    rot_row = lo;
    rot_col = SIDE_W'(lo + k);
    case (phase[1:0])
      2'd0: begin
        rot_row = lo;
        rot_col = SIDE_W'(lo + k);
      end
      2'd1: begin
        rot_row = SIDE_W'(hi - k);
        rot_col = lo;
      end
      2'd2: begin
        rot_row = hi;
        rot_col = SIDE_W'(hi - k);
      end
      default: begin
        rot_row = SIDE_W'(lo + k);
        rot_col = hi;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_load = rd_pend;
    cmd.out_zero = !rd_inside;
    rd_row       = SIDE_W'(row);
    rd_col       = SIDE_W'(col);
    wr_row       = SIDE_W'(row);
    wr_col       = SIDE_W'(col);
    unique case (state)
      ST_IDLE: begin
        cmd.rd_en = accept && (opcode == mrot_pkg::OP_READ) && in_range;
        cmd.wr_en = accept && (opcode == mrot_pkg::OP_WRITE) && in_range;
      end
      ST_ROT: begin
        // phases 0..3 read the corners, 4..7 write them back shifted
        rd_row           = rot_row;
        rd_col           = rot_col;
        wr_row           = rot_row;
        wr_col           = rot_col;
        cmd.rd_en        = !phase[2];
        cmd.wr_en        = phase[2];
        cmd.wr_from_hold = 1'b1;
        cmd.hold_sel     = phase[1:0] + 2'd1;
        cmd.cap_en       = (phase >= 3'd1) && (phase <= 3'd4);
        cmd.cap_idx      = phase[1:0] - 2'd1;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      lo        <= '0;
      hi        <= '0;
      k         <= '0;
      rd_pend   <= 1'b0;
      rd_inside <= 1'b0;
      out_valid <= 1'b0;
      size_reg  <= mrot_pkg::SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg <= cfg_data;
      end
      rd_pend   <= accept && (opcode == mrot_pkg::OP_READ);
      rd_inside <= in_range;
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (opcode == mrot_pkg::OP_ROTATE) && (32'(n_eff) >= 32'd2)) begin
            state <= ST_ROT;
            phase <= '0;
            lo    <= '0;
            hi    <= n_minus1;
            k     <= '0;
          end
        end
        ST_ROT: begin
          phase <= phase + 3'd1;
          if (phase == 3'd7) begin
            if (more_k) begin
              k <= k + SIDE_W'(1);
            end else begin
              k  <= '0;
              lo <= lo + SIDE_W'(1);
              hi <= hi - SIDE_W'(1);
              if (!more_layer) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/matrix_rotate_90_clockwise_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_rotate_90_clockwise_core
// Square matrix store with element write, element read and in-place
// clockwise rotation of the active corner
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------
//  in       | to core   | in_valid / in_stall  | opcode, row, col, value
//  out      | from core | out_valid / out_stall| read_value
//  cfg      | to core   | cfg_valid / cfg_ready| cfg_data (matrix size)
//
//  write and ignored items do not stall the input; a read registers its
//  element and then its result, and holds the next item off meanwhile
//  rotate runs four-element steps over the single-port store, with the
//  input stalled throughout
//  reset clears control and sets the size to 16; the store is not cleared
//  a stalled result holds the input off until it is taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_rotate_90_clockwise_core #(
  parameter int MAX_SIDE = mrot_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mrot_pkg::OPCODE_W-1:0]       opcode,
  input  logic [mrot_pkg::INDEX_W-1:0]        row,
  input  logic [mrot_pkg::INDEX_W-1:0]        col,
  input  logic signed [mrot_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mrot_pkg::DATA_W-1:0]  read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrot_pkg::SIZE_W-1:0]         cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE);

  mrot_pkg::dp_cmd_t cmd;
  logic [SIDE_W-1:0] rd_row;
  logic [SIDE_W-1:0] rd_col;
  logic [SIDE_W-1:0] wr_row;
  logic [SIDE_W-1:0] wr_col;

  mrot_ctrl #(
    .MAX_SIDE (MAX_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .wr_row    (wr_row),
    .wr_col    (wr_col)
  );

  mrot_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .rd_row     (rd_row),
    .rd_col     (rd_col),
    .wr_row     (wr_row),
    .wr_col     (wr_col),
    .wr_value   (value),
    .read_value (read_value)
  );

  // single-port store use: never a read and a write in one cycle
  `ASSERT_NEVER(a_no_rw_same_cycle, clk, rst, cmd.rd_en && cmd.wr_en, "read and write together")

  // rotation write-back only while the input is held off
  `ASSERT_CLK(a_rot_stalls, clk, rst, (cmd.wr_en && cmd.wr_from_hold) |-> in_stall, "rotation without stall")

  // a new result appears only after a read item was taken, by way of rd_pend
  `ASSERT_CLK(a_result_from_read, clk, rst, $rose(out_valid) |-> $past(in_valid && !in_stall && (opcode == mrot_pkg::OP_READ), 2), "result without read item")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives element writes, reads and clockwise rotations into the matrix core
// over a series of matrix sizes, predicts each read in a scoreboard that
// keeps its own copy of the store, and compares every read item as it leaves
// ----------------------------------------------------------------------------

class rotate_scoreboard;
  localparam int SIDE = mrot_pkg::MAX_SIDE_DEFAULT;

  // bit 32 marks an entry that holds a written element
  bit [32:0]   cells [SIDE][SIDE];
  logic [4:0]  size_reg;
  logic [31:0] read_queue [$];
  int          errors;

  function new();
    size_reg = mrot_pkg::SIZE_RESET;
    errors = 0;
  endfunction

  function int active_side();
    return (size_reg > SIDE) ? SIDE : int'(size_reg);
  endfunction

  function int pending();
    return read_queue.size();
  endfunction

  function void set_size(logic [4:0] size);
    size_reg = size;
  endfunction

  function void note_input(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic [31:0] v);
    int n;
    int lo;
    int hi;
    int k;
    bit hit;
    bit [32:0] held;
    n = active_side();
    hit = (r < n) && (c < n);
    case (op)
      mrot_pkg::OP_WRITE: begin
        if (hit) cells[r][c] = {1'b1, v};
      end
      mrot_pkg::OP_ROTATE: begin
        // outer ring first, four elements per step
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
          for (k = 0; k < hi - lo; k++) begin
            held = cells[lo][lo+k];
            cells[lo][lo+k] = cells[hi-k][lo];
            cells[hi-k][lo] = cells[hi][hi-k];
            cells[hi][hi-k] = cells[lo+k][hi];
            cells[lo+k][hi] = held;
          end
          lo++;
          hi--;
        end
      end
      mrot_pkg::OP_READ: begin
        read_queue.insert(read_queue.size(), hit ? cells[r][c][31:0] : 32'd0);
      end
      default: begin
      end
    endcase
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [31:0] got);
    logic [31:0] want;
    if (read_queue.size() == 0) begin
      report($sformatf("read_value %h with no read pending", got));
    end else begin
      want = read_queue.pop_front();
      if (got !== want) report($sformatf("read_value %h, predicted %h", got, want));
    end
  endtask
endclass

module tb;

  localparam logic [mrot_pkg::OPCODE_W-1:0] OP_NONE = 2'd3;
  // longest rotation at full size plus margin
  localparam int ROT_DRAIN =
    8 * (mrot_pkg::MAX_SIDE_DEFAULT * mrot_pkg::MAX_SIDE_DEFAULT / 4) + 32;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [mrot_pkg::OPCODE_W-1:0]      opcode = '0;
  logic [mrot_pkg::INDEX_W-1:0]       row = '0;
  logic [mrot_pkg::INDEX_W-1:0]       col = '0;
  logic signed [mrot_pkg::DATA_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [mrot_pkg::DATA_W-1:0] read_value;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [mrot_pkg::SIZE_W-1:0]        cfg_data = '0;

  rotate_scoreboard sb;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #1 clk = ~clk;

  matrix_rotate_90_clockwise_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .row        (row),
    .col        (col),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void pick_item(output logic [1:0] op, output logic [3:0] r,
                                    output logic [3:0] c, output logic [31:0] v);
    int n;
    int roll;
    n = sb.active_side();
    v = pick_value();
    r = 4'($urandom_range(0, 15));
    c = 4'($urandom_range(0, 15));
    op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 80) begin
      roll = $urandom_range(0, 99);
      if (n == 0) begin
        op = 2'($urandom_range(0, 2));
      end else if (roll < 45) begin
        op = mrot_pkg::OP_WRITE;
        r = 4'($urandom_range(0, n - 1));
        c = 4'($urandom_range(0, n - 1));
      end else if (roll < ((n > 8) ? 47 : 53)) begin
        op = mrot_pkg::OP_ROTATE;
      end else begin
        op = mrot_pkg::OP_READ;
        r = 4'($urandom_range(0, n - 1));
        c = 4'($urandom_range(0, n - 1));
        repeat (8) begin
          if (!sb.cells[r][c][32]) begin
            r = 4'($urandom_range(0, n - 1));
            c = 4'($urandom_range(0, n - 1));
          end
        end
      end
    end
    // keep reads off entries that never held a written element
    if (op == mrot_pkg::OP_READ && r < n && c < n && !sb.cells[r][c][32]) begin
      if (n < 16) r = 4'($urandom_range(n, 15));
      else op = mrot_pkg::OP_WRITE;
    end
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                           input logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    row      <= r;
    col      <= c;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, r, c, v);
  endtask

  task automatic write_size(input int size);
    // idle: no read in flight and any rotation finished
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (ROT_DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size[mrot_pkg::SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(size[mrot_pkg::SIZE_W-1:0]);
  endtask

  task automatic run_phase(input int size, input int count, input bit q);
    int n;
    logic [1:0]  op;
    logic [3:0]  r;
    logic [3:0]  c;
    logic [31:0] v;
    quiet = q;
    write_size(size);
    n = sb.active_side();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!sb.cells[i][j][32]) send_item(mrot_pkg::OP_WRITE, 4'(i), 4'(j), pick_value());
      end
    end
    repeat (count) begin
      pick_item(op, r, c, v);
      send_item(op, r, c, v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(read_value);
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 2x2 corner with extreme values, one turn, then out of range cases
    write_size(2);
    send_item(mrot_pkg::OP_WRITE, 0, 0, 32'h7fff_ffff);
    send_item(mrot_pkg::OP_WRITE, 0, 1, 32'h8000_0000);
    send_item(mrot_pkg::OP_WRITE, 1, 0, 32'hffff_ffff);
    send_item(mrot_pkg::OP_WRITE, 1, 1, 32'h0000_0000);
    send_item(mrot_pkg::OP_READ, 0, 0, $urandom);
    send_item(mrot_pkg::OP_READ, 0, 1, $urandom);
    send_item(mrot_pkg::OP_READ, 1, 0, $urandom);
    send_item(mrot_pkg::OP_READ, 1, 1, $urandom);
    send_item(mrot_pkg::OP_ROTATE, 15, 15, $urandom);
    send_item(mrot_pkg::OP_READ, 0, 0, $urandom);
    send_item(mrot_pkg::OP_READ, 0, 1, $urandom);
    send_item(mrot_pkg::OP_READ, 1, 1, $urandom);
    send_item(mrot_pkg::OP_READ, 1, 0, $urandom);
    send_item(OP_NONE, 15, 15, $urandom);
    send_item(mrot_pkg::OP_WRITE, 15, 15, 32'h1234_5678);
    send_item(mrot_pkg::OP_READ, 15, 15, $urandom);
    send_item(mrot_pkg::OP_READ, 0, 2, $urandom);
    // empty corner: everything ignored, reads give zero
    write_size(0);
    send_item(mrot_pkg::OP_WRITE, 0, 0, 32'h5a5a_5a5a);
    send_item(mrot_pkg::OP_READ, 0, 0, $urandom);
    send_item(mrot_pkg::OP_ROTATE, 0, 0, $urandom);
    // single element: rotation leaves it alone
    write_size(1);
    send_item(mrot_pkg::OP_ROTATE, 0, 0, $urandom);
    send_item(mrot_pkg::OP_READ, 0, 0, $urandom);

    run_phase(3, 100, 1'b0);
    run_phase(16, 120, 1'b0);
    run_phase(31, 100, 1'b1);
    run_phase(5, 120, 1'b0);
    run_phase(17, 80, 1'b0);
    run_phase(8, 120, 1'b1);
    run_phase(0, 30, 1'b0);
    run_phase(1, 40, 1'b0);
    run_phase(2, 80, 1'b0);
    run_phase(4, 100, 1'b0);
    run_phase($urandom_range(0, 31), 80, 1'b0);
    run_phase(12, 100, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mrot_pkg.sv
hdl/mrot_dp.sv
hdl/mrot_ctrl.sv
hdl/matrix_rotate_90_clockwise_core.sv
dv/tb.sv
